@@ rtl/clipped_alpha_blend_unit_assert.svh @@
// Assertion macros shared by the clipped alpha blend RTL.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef CLIPPED_ALPHA_BLEND_UNIT_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_UNIT_ASSERT_SVH

// same-cycle implication
`define CAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cab_pkg.sv @@
// Types and constants for the clipped alpha blend unit.
// No dependencies; used by cab_blend and clipped_alpha_blend_unit.
package cab_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned PixW   = ChanW * NumCh;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 13;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [PixW-1:0]   pixel_t;
  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CfgW-1:0]   cfg_word_t;

  typedef enum logic [1:0] {
    CFG_OFFSET_X    = 2'd0,
    CFG_OFFSET_Y    = 2'd1,
    CFG_DEST_WIDTH  = 2'd2,
    CFG_DEST_HEIGHT = 2'd3
  } cfg_idx_e;

  localparam chan_t ALPHA_CLEAR  = 8'h00;
  localparam chan_t ALPHA_OPAQUE = 8'hFF;

endpackage

@@ rtl/cab_blend.sv @@
// Four-channel RGBA8 "over" blend, alpha taken from the sprite top byte.
// Combinational; uses cab_pkg types.
module cab_blend (
  input  cab_pkg::pixel_t sprite_px_i,
  input  cab_pkg::pixel_t dest_px_i,
  output cab_pkg::pixel_t blend_px_o
);

  // round(n/255) for n <= 255*255, exact (quotient is never a half)
  function automatic cab_pkg::chan_t div255_round(input logic [15:0] n);
    logic [16:0] t;
    logic [16:0] r;
    t = {1'b0, n} + 17'd128;
    r = (t + (t >> 8)) >> 8;
    return r[7:0];
  endfunction

  cab_pkg::chan_t alpha;
  cab_pkg::chan_t inv_alpha;

  assign alpha     = sprite_px_i[cab_pkg::PixW-1 -: cab_pkg::ChanW];
  assign inv_alpha = cab_pkg::ALPHA_OPAQUE - alpha;

  for (genvar ch = 0; ch < cab_pkg::NumCh; ch++) begin : g_ch
    cab_pkg::chan_t s_c;
    cab_pkg::chan_t d_c;
    logic [15:0]    s_prod;
    logic [15:0]    d_prod;
    logic [8:0]     sum;

    assign s_c    = sprite_px_i[ch*cab_pkg::ChanW +: cab_pkg::ChanW];
    assign d_c    = dest_px_i[ch*cab_pkg::ChanW +: cab_pkg::ChanW];
    assign s_prod = alpha * s_c;
    assign d_prod = inv_alpha * d_c;
    assign sum    = {1'b0, div255_round(s_prod)} + {1'b0, div255_round(d_prod)};
    assign blend_px_o[ch*cab_pkg::ChanW +: cab_pkg::ChanW] =
      sum[8] ? cab_pkg::ALPHA_OPAQUE : sum[7:0];
  end

endmodule

@@ rtl/clipped_alpha_blend_unit.sv @@
// Clipped alpha blend unit: sprite pixel placement, clipping and RGBA8 blend.
// Depends on cab_pkg, cab_blend and clipped_alpha_blend_unit_assert.svh.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one beat carries a sprite pixel,
//    its column and row in the sprite, and the destination pixel under it.
//  - Output channel (out_valid_o/out_ready_i): one beat per input beat with
//    write flag, destination x/y (low 12 bits of the sums) and the new pixel.
//  - Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (offset x, offset y, dest width, dest height). Write only while idle.
//    Width and height are clamped to MAX_DIM when written.
//  - Pipeline: input register then result register; all math sits between
//    the two registers. Throughput: one beat per cycle while out_ready_i is high.
//  - Reset: pipeline empties, all config registers return to 0 (every target
//    is outside until a size is written).
//  - Receiver stall: the result register holds, the input register holds one
//    more beat behind it, then in_ready_o drops until out_ready_i returns.
`include "clipped_alpha_blend_unit_assert.svh"

module clipped_alpha_blend_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  cab_pkg::cfg_word_t   cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cab_pkg::coord_t      sprite_col_i,
  input  cab_pkg::coord_t      sprite_row_i,
  input  cab_pkg::pixel_t      sprite_pixel_i,
  input  cab_pkg::pixel_t      dest_pixel_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 write_enable_o,
  output cab_pkg::coord_t      dest_x_o,
  output cab_pkg::coord_t      dest_y_o,
  output cab_pkg::pixel_t      new_pixel_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW = (DimW > cab_pkg::CfgW) ? DimW : cab_pkg::CfgW;
  localparam logic [CmpW-1:0] MaxDimC = CmpW'(MAX_DIM);

  // config registers
  cab_pkg::cfg_word_t off_x_q, off_y_q, width_q, height_q;
  cab_pkg::cfg_word_t clamped_val;

  assign clamped_val = (CmpW'(cfg_wdata_i) > MaxDimC) ? cab_pkg::CfgW'(MaxDimC)
                                                      : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (cab_pkg::cfg_idx_e'(cfg_idx_i))
        cab_pkg::CFG_OFFSET_X:    off_x_q  <= cfg_wdata_i;
        cab_pkg::CFG_OFFSET_Y:    off_y_q  <= cfg_wdata_i;
        cab_pkg::CFG_DEST_WIDTH:  width_q  <= clamped_val;
        cab_pkg::CFG_DEST_HEIGHT: height_q <= clamped_val;
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid_q;
  cab_pkg::coord_t    col_q, row_q;
  cab_pkg::pixel_t    spix_q, dpix_q;
  logic               s1_adv;
  logic               in_fire;

  assign s1_adv     = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q  <= sprite_col_i;
      row_q  <= sprite_row_i;
      spix_q <= sprite_pixel_i;
      dpix_q <= dest_pixel_i;
    end
  end

  // placement and clipping
  logic signed [13:0] tx, ty;
  logic               in_x, in_y, we;
  cab_pkg::chan_t     alpha;
  cab_pkg::pixel_t    blend_px;
  cab_pkg::pixel_t    np;

  assign tx    = $signed({2'b00, col_q}) + $signed({off_x_q[12], off_x_q});
  assign ty    = $signed({2'b00, row_q}) + $signed({off_y_q[12], off_y_q});
  assign in_x  = !tx[13] && (tx[12:0] < width_q);
  assign in_y  = !ty[13] && (ty[12:0] < height_q);
  assign alpha = spix_q[cab_pkg::PixW-1 -: cab_pkg::ChanW];
  assign we    = in_x && in_y && (alpha != cab_pkg::ALPHA_CLEAR);

  cab_blend u_blend (
    .sprite_px_i (spix_q),
    .dest_px_i   (dpix_q),
    .blend_px_o  (blend_px)
  );

  always_comb begin
    np = dpix_q;
    if (we) begin
      np = (alpha == cab_pkg::ALPHA_OPAQUE) ? spix_q : blend_px;
    end
  end

  // result register
  logic            out_valid_q;
  logic            write_enable_q;
  cab_pkg::coord_t dest_x_q, dest_y_q;
  cab_pkg::pixel_t new_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      write_enable_q <= we;
      dest_x_q       <= tx[11:0];
      dest_y_q       <= ty[11:0];
      new_pixel_q    <= np;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = write_enable_q;
  assign dest_x_o       = dest_x_q;
  assign dest_y_o       = dest_y_q;
  assign new_pixel_o    = new_pixel_q;

  `CAB_ASSERT_NEXT(a_in_lands, in_fire, s1_valid_q, "accepted beat missing from input stage")
  `CAB_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q, "stalled beat dropped")
  `CAB_ASSERT_NEXT(a_s1_moves, s1_valid_q && s1_adv, out_valid_q, "beat lost between stages")
  `CAB_ASSERT_IMPL(a_ready_free, !out_valid_q, in_ready_o, "input blocked with empty result")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for clipped_alpha_blend_unit: directed and random sprite beats
// under changing offsets, sizes and handshake pressure. Depends on cab_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int MaxDim   = 4096;
  localparam int CycLimit = 400000;
  localparam int NumPhase = 8;
  localparam int PhaseLen = 140;

  typedef struct {
    cab_pkg::coord_t col;
    cab_pkg::coord_t row;
    cab_pkg::pixel_t spix;
    cab_pkg::pixel_t dpix;
    bit              drain_first;
  } sprite_beat_t;

  typedef struct packed {
    logic            we;
    cab_pkg::coord_t x;
    cab_pkg::coord_t y;
    cab_pkg::pixel_t pix;
  } blend_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  cab_pkg::cfg_word_t cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  cab_pkg::coord_t    sprite_col_i = '0;
  cab_pkg::coord_t    sprite_row_i = '0;
  cab_pkg::pixel_t    sprite_pixel_i = '0;
  cab_pkg::pixel_t    dest_pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               write_enable_o;
  cab_pkg::coord_t    dest_x_o;
  cab_pkg::coord_t    dest_y_o;
  cab_pkg::pixel_t    new_pixel_o;

  clipped_alpha_blend_unit #(.MAX_DIM(MaxDim)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .sprite_col_i, .sprite_row_i, .sprite_pixel_i, .dest_pixel_i,
    .out_valid_o, .out_ready_i, .write_enable_o, .dest_x_o, .dest_y_o, .new_pixel_o
  );

  logic signed [cab_pkg::CfgW-1:0] cur_off_x = '0;
  logic signed [cab_pkg::CfgW-1:0] cur_off_y = '0;
  cab_pkg::cfg_word_t cur_width = '0;
  cab_pkg::cfg_word_t cur_height = '0;

  sprite_beat_t  pending_beats[$];
  blend_result_t expected_results[$];
  int queued = 0;
  int accepted = 0;
  int checked = 0;
  int n_written = 0;
  int reg_writes = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int size_limit(cab_pkg::cfg_word_t s);
    return (int'(s) > MaxDim) ? MaxDim : int'(s);
  endfunction

  function automatic cab_pkg::pixel_t blend_over(cab_pkg::pixel_t s, cab_pkg::pixel_t d,
                                                 cab_pkg::chan_t a);
    cab_pkg::pixel_t res;
    int unsigned sc, dc, sum;
    res = '0;
    for (int ch = 0; ch < cab_pkg::NumCh; ch++) begin
      sc = s[ch*cab_pkg::ChanW +: cab_pkg::ChanW];
      dc = d[ch*cab_pkg::ChanW +: cab_pkg::ChanW];
      sum = (2 * a * sc + 255) / 510 + (2 * (255 - a) * dc + 255) / 510;
      if (sum > 255) sum = 255;
      res[ch*cab_pkg::ChanW +: cab_pkg::ChanW] = sum[cab_pkg::ChanW-1:0];
    end
    return res;
  endfunction

  function automatic blend_result_t predict_pixel(cab_pkg::coord_t col, cab_pkg::coord_t row,
                                                  cab_pkg::pixel_t spix,
                                                  cab_pkg::pixel_t dpix);
    blend_result_t r;
    int tx, ty;
    cab_pkg::chan_t a;
    logic in_win;
    a = spix[cab_pkg::PixW-1 -: cab_pkg::ChanW];
    tx = int'(col) + int'(cur_off_x);
    ty = int'(row) + int'(cur_off_y);
    in_win = tx >= 0 && tx < size_limit(cur_width) && ty >= 0 && ty < size_limit(cur_height);
    r.we = in_win && a != cab_pkg::ALPHA_CLEAR;
    r.x = cab_pkg::coord_t'(tx);
    r.y = cab_pkg::coord_t'(ty);
    if (!r.we) r.pix = dpix;
    else if (a == cab_pkg::ALPHA_OPAQUE) r.pix = spix;
    else r.pix = blend_over(spix, dpix, a);
    return r;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    sprite_beat_t nb;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_pixel(sprite_col_i, sprite_row_i, sprite_pixel_i,
                                                 dest_pixel_i));
        accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle &&
            !(pending_beats[0].drain_first && expected_results.size() != 0)) begin
          nb = pending_beats.pop_front();
          in_valid_i     <= 1'b1;
          sprite_col_i   <= nb.col;
          sprite_row_i   <= nb.row;
          sprite_pixel_i <= nb.spix;
          dest_pixel_i   <= nb.dpix;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    blend_result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: we=%0b x=%0d y=%0d pix=%08h",
                     write_enable_o, dest_x_o, dest_y_o, new_pixel_o);
        end else begin
          e = expected_results.pop_front();
          checked++;
          if (e.we) n_written++;
          if (write_enable_o !== e.we || dest_x_o !== e.x || dest_y_o !== e.y ||
              new_pixel_o !== e.pix) begin
            errors++;
            if (errors <= 10)
              $display("mismatch beat %0d: exp we=%0b x=%0d y=%0d pix=%08h,",
                       checked, e.we, e.x, e.y, e.pix,
                       " got we=%0b x=%0d y=%0d pix=%08h",
                       write_enable_o, dest_x_o, dest_y_o, new_pixel_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               expected_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  task automatic add_beat(cab_pkg::coord_t col, cab_pkg::coord_t row, cab_pkg::pixel_t spix,
                          cab_pkg::pixel_t dpix, bit drain = 1'b0);
    sprite_beat_t b;
    b.col = col;
    b.row = row;
    b.spix = spix;
    b.dpix = dpix;
    b.drain_first = drain;
    pending_beats.push_back(b);
    queued++;
  endtask

  task automatic wait_drain();
    while (accepted != queued || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cab_pkg::cfg_idx_e idx, cab_pkg::cfg_word_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cab_pkg::CFG_OFFSET_X:    cur_off_x = val;
      cab_pkg::CFG_OFFSET_Y:    cur_off_y = val;
      cab_pkg::CFG_DEST_WIDTH:  cur_width = val;
      cab_pkg::CFG_DEST_HEIGHT: cur_height = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(cab_pkg::cfg_word_t ox, cab_pkg::cfg_word_t oy,
                            cab_pkg::cfg_word_t w, cab_pkg::cfg_word_t h);
    write_reg(cab_pkg::CFG_OFFSET_X, ox);
    write_reg(cab_pkg::CFG_OFFSET_Y, oy);
    write_reg(cab_pkg::CFG_DEST_WIDTH, w);
    write_reg(cab_pkg::CFG_DEST_HEIGHT, h);
  endtask

  function automatic cab_pkg::cfg_word_t rand_offset();
    if ($urandom_range(0, 3) == 0) return cab_pkg::cfg_word_t'($urandom());
    return cab_pkg::cfg_word_t'(int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic cab_pkg::cfg_word_t rand_size();
    case ($urandom_range(0, 7))
      0: return cab_pkg::cfg_word_t'(MaxDim);
      1: return cab_pkg::cfg_word_t'($urandom_range(MaxDim + 1, 8191));
      2: return cab_pkg::cfg_word_t'($urandom_range(1, 64));
      3: return '0;
      default: return cab_pkg::cfg_word_t'($urandom_range(1, MaxDim));
    endcase
  endfunction

  // biased toward the clip edges of the current window
  function automatic cab_pkg::coord_t pick_coord(int off, int lim);
    int t;
    case ($urandom_range(0, 9))
      0, 1, 2: return cab_pkg::coord_t'($urandom());
      3: t = -1;
      4: t = 0;
      5: t = lim - 1;
      6: t = lim;
      default: t = (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
    endcase
    return cab_pkg::coord_t'(t - off);
  endfunction

  function automatic cab_pkg::pixel_t rand_sprite_pixel();
    cab_pkg::pixel_t p;
    p = $urandom();
    case ($urandom_range(0, 9))
      0: p[cab_pkg::PixW-1 -: cab_pkg::ChanW] = cab_pkg::ALPHA_CLEAR;
      1: p[cab_pkg::PixW-1 -: cab_pkg::ChanW] = cab_pkg::ALPHA_OPAQUE;
      2: p[cab_pkg::PixW-1 -: cab_pkg::ChanW] = 8'd1;
      3: p[cab_pkg::PixW-1 -: cab_pkg::ChanW] = 8'd254;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int idle_send[4];
    int idle_recv[4];
    idle_send = '{0, 60, 0, 7};
    idle_recv = '{0, 0, 60, 7};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full window at origin
    set_config(13'd0, 13'd0, 13'd4096, 13'd4096);
    add_beat(12'd0, 12'd0, 32'h00123456, 32'hDEADBEEF);
    add_beat(12'd4095, 12'd4095, 32'hFFFFFFFF, 32'h00000000);
    add_beat(12'd7, 12'd9, 32'hFF000000, 32'hFFFFFFFF);
    add_beat(12'd1, 12'd2, 32'h01FFFFFF, 32'h00000000);
    add_beat(12'd3, 12'd4, 32'hFE000000, 32'hFFFFFFFF);
    add_beat(12'd100, 12'd200, 32'h80FF00FF, 32'h7F80FF00);
    add_beat(12'd5, 12'd5, 32'h80FFFFFF, 32'hFEFEFEFE);
    add_beat(12'd0, 12'd0, 32'h00000000, 32'h00000000);
    add_beat(12'd2048, 12'd1024, 32'hAA55AA55, 32'h55AA55AA);
    add_beat(12'd4095, 12'd0, 32'h7F7F7F7F, 32'h80808080);
    wait_drain();

    // negative targets, oversized window
    set_config(13'h1FFF, 13'h1FFF, 13'd8191, 13'd8191);
    add_beat(12'd0, 12'd5, 32'hFFABCDEF, 32'h11111111);
    add_beat(12'd5, 12'd0, 32'h40ABCDEF, 32'h22222222);
    add_beat(12'd1, 12'd1, 32'hC0FF8000, 32'h00FF80FF);
    add_beat(12'd4095, 12'd4095, 32'hFFFFFFFF, 32'h33333333);
    wait_drain();

    // far offset, width just above the clamp
    set_config(13'd4095, 13'd4095, 13'd4097, 13'd8191);
    add_beat(12'd0, 12'd0, 32'hFF010203, 32'h44444444);
    add_beat(12'd1, 12'd0, 32'hFF010203, 32'h55555555);
    add_beat(12'd0, 12'd1, 32'h80010203, 32'h66666666);
    wait_drain();

    // zero size
    set_config(13'h1000, 13'd4095, 13'd0, 13'd0);
    add_beat(12'd4095, 12'd0, 32'hFF00FF00, 32'h77777777);
    add_beat(12'd0, 12'd4095, 32'h7F00FF00, 32'h88888888);
    wait_drain();

    for (int p = 0; p < NumPhase; p++) begin
      send_idle = idle_send[p % 4];
      recv_stall = idle_recv[p % 4];
      set_config(rand_offset(), rand_offset(), rand_size(), rand_size());
      for (int i = 0; i < PhaseLen; i++)
        add_beat(pick_coord(int'(cur_off_x), size_limit(cur_width)),
                 pick_coord(int'(cur_off_y), size_limit(cur_height)),
                 rand_sprite_pixel(), cab_pkg::pixel_t'($urandom()),
                 (p == 2 && i == PhaseLen / 2) || $urandom_range(0, 63) == 0);
      wait_drain();
    end

    repeat (6) @(posedge clk_i);
    $display("%0d beats checked, %0d of them writes, across %0d register writes",
             checked, n_written, reg_writes);
    $display("handshake modes: free flow, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cab_pkg.sv
rtl/cab_blend.sv
rtl/clipped_alpha_blend_unit.sv
tb/sv/testbench.sv
